// File: rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared sizes, payload structs, command and status codes, controller states
// and small arithmetic helpers for the thread scheduler core.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MaxThreads   = 16;
  localparam int ThreadBits   = 4;
  localparam int Levels       = 4;
  localparam int LevelBits    = 2;
  localparam int CountBits    = 5;
  localparam int TimeBits     = 32;
  localparam int QuantumBits  = 22;
  localparam int QmsBits      = 10;
  localparam int PeriodBits   = 8;
  localparam int BaseBits     = 20;
  localparam int UsPerMs      = 1000;
  localparam int FifoDepth    = Levels * MaxThreads;
  localparam int FifoAddrBits = LevelBits + ThreadBits;

  localparam logic [QuantumBits-1:0] QuantumMax = 22'd4194303;
  localparam logic [QmsBits-1:0]     QmsReset   = 10'd50;
  localparam logic [PeriodBits-1:0]  PeriodReset = 8'd100;

  typedef logic [ThreadBits-1:0] thread_t;
  typedef logic [LevelBits-1:0]  level_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [TimeBits-1:0]   time_t;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_TIMEOUT = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_EXIT    = 3'd3,
    CMD_JOIN    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic {
    CFG_QUANTUM = 1'b0,
    CFG_PERIOD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PR_POP,
    S_PR_BORN,
    S_PR_INS,
    S_PR_PUSH,
    S_ACT,
    S_WAKE,
    S_PICK,
    S_PICK_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    thread_t    target_thread;
    time_t      now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    thread_t                thread;
    level_t                 level;
    logic [QuantumBits-1:0] quantum_us;
    logic                   switched;
  } out_item_t;

  // Number of threads kept per level when a queue of n entries is spread
  // from level s: n / (s + 1). n never exceeds MaxThreads here.
  function automatic count_t share_of(input count_t n, input level_t s);
    logic [9:0] prod;
    begin
      prod = {5'b0, n} * 10'd11;
      case (s)
        2'd1:    share_of = n >> 1;
        2'd2:    share_of = prod[9:5];
        2'd3:    share_of = n >> 2;
        default: share_of = n;
      endcase
    end
  endfunction

  // Slice in microseconds for a level, saturating at the field maximum.
  function automatic logic [QuantumBits-1:0] slice_us(input logic [BaseBits-1:0] base,
                                                     input level_t lv);
    logic [22:0] prod;
    begin
      prod = 23'(base) * 23'({1'b0, lv} + 3'd1);
      if (prod > 23'(QuantumMax)) begin
        slice_us = QuantumMax;
      end else begin
        slice_us = prod[QuantumBits-1:0];
      end
    end
  endfunction

endpackage

// File: rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// MLFQ generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int Width = 4,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mlfq_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// MLFQ thread scheduler core
// Multilevel feedback scheduler over 16 thread slots and 4 levels. Level
// queues and birth times live in synchronous RAMs; a sequencer reads,
// modifies and writes them back one step per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | in_data  (cmd, target_thread, now)
//  out     | output    | out_valid / out_stall| out_data (status, thread, level, ...)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A create or a report passes DECODE and OUT; an event passes DECODE, ACT,
// PICK, PICK_RD (skipped when nothing is runnable) and OUT, plus WAKE steps
// over the join stack on exit, plus a promotion pass of PR_POP, PR_BORN and
// PR_INS per queued thread and PR_PUSH per thread of each lower level.
// Reset is synchronous and needs no clearing pass. A new beat is taken while
// a finished result waits in the output register.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mlfq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mlfq_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [mlfq_pkg::QmsBits-1:0] cfg_data
);

  mlfq_pkg::state_t state, state_next;
  mlfq_pkg::in_item_t in_q;
  mlfq_pkg::out_item_t res;

  logic [mlfq_pkg::QmsBits-1:0]    quantum_ms;
  logic [mlfq_pkg::PeriodBits-1:0] rebalance_period;
  logic [mlfq_pkg::BaseBits-1:0]   quantum_base;

  mlfq_pkg::thread_t fifo_head [mlfq_pkg::Levels];
  mlfq_pkg::count_t  fifo_count [mlfq_pkg::Levels];
  mlfq_pkg::level_t  thread_level [mlfq_pkg::MaxThreads];
  logic [mlfq_pkg::MaxThreads-1:0] thread_live;
  logic [mlfq_pkg::MaxThreads-1:0] thread_dead;
  mlfq_pkg::thread_t join_target [mlfq_pkg::MaxThreads];
  mlfq_pkg::thread_t join_stack [mlfq_pkg::MaxThreads];
  mlfq_pkg::count_t  join_depth;
  mlfq_pkg::thread_t running_thread;
  logic [mlfq_pkg::PeriodBits-1:0] event_count;
  mlfq_pkg::count_t  next_slot;
  logic              cpu_idle;

  mlfq_pkg::thread_t sort_buffer [mlfq_pkg::MaxThreads];
  mlfq_pkg::time_t   ages [mlfq_pkg::MaxThreads];
  mlfq_pkg::count_t  sort_n;
  mlfq_pkg::level_t  prom_lvl;
  mlfq_pkg::count_t  dist_idx;
  mlfq_pkg::level_t  dist_dst;
  mlfq_pkg::count_t  dist_k;
  mlfq_pkg::count_t  dist_share;
  mlfq_pkg::thread_t pop_thr;
  mlfq_pkg::count_t  wake_i;
  mlfq_pkg::level_t  pick_lvl;

  // RAM ports
  logic                              fifo_we;
  logic [mlfq_pkg::FifoAddrBits-1:0] fifo_waddr;
  logic [mlfq_pkg::FifoAddrBits-1:0] fifo_raddr;
  mlfq_pkg::thread_t                 fifo_rdata;
  logic                              born_we;
  mlfq_pkg::thread_t                 born_raddr;
  mlfq_pkg::time_t                   born_rdata;

  // Queue control
  logic              push_en, push_ok, pop_en;
  mlfq_pkg::level_t  push_lv, pop_lv;
  mlfq_pkg::thread_t push_thr;

  // Decode helpers
  logic              in_take, out_free;
  mlfq_pkg::level_t  cur_lv, tmo_lv;
  logic [mlfq_pkg::QuantumBits-1:0] rep_q;
  mlfq_pkg::level_t  rep_lv;
  logic              is_event, promote;
  logic [mlfq_pkg::PeriodBits-1:0] ev_next;
  logic              pick_found;
  mlfq_pkg::level_t  pick_sel;
  mlfq_pkg::thread_t wake_idx, wake_thr;
  logic              wake_hit;
  logic              dist_more;
  mlfq_pkg::thread_t dist_thr;
  mlfq_pkg::time_t   age_new;
  mlfq_pkg::count_t  ins_pos;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign cur_lv = thread_level[running_thread];
  assign tmo_lv = (cur_lv == mlfq_pkg::LevelBits'(mlfq_pkg::Levels - 1)) ? cur_lv
                : cur_lv + 1'b1;
  assign rep_lv = cpu_idle ? '0 : cur_lv;
  assign rep_q  = cpu_idle ? '0 : mlfq_pkg::slice_us(quantum_base, cur_lv);

  assign is_event = (in_q.cmd == mlfq_pkg::CMD_TIMEOUT) ||
                    (in_q.cmd == mlfq_pkg::CMD_YIELD)   ||
                    (in_q.cmd == mlfq_pkg::CMD_EXIT)    ||
                    ((in_q.cmd == mlfq_pkg::CMD_JOIN) &&
                     thread_live[in_q.target_thread] && !thread_dead[in_q.target_thread]);
  assign ev_next = event_count + 1'b1;
  assign promote = ev_next >= rebalance_period;

  assign wake_idx = mlfq_pkg::ThreadBits'(wake_i - 1'b1);
  assign wake_thr = join_stack[wake_idx];
  assign wake_hit = (wake_i != '0) && (join_target[wake_idx] == running_thread);

  assign dist_more = dist_idx < sort_n;
  assign dist_thr  = sort_buffer[dist_idx[mlfq_pkg::ThreadBits-1:0]];

  // Slot 0 counts as born at time zero; its birth time is never written.
  assign age_new = in_q.now - ((pop_thr == '0) ? '0 : born_rdata);

  // Insertion point: before the first entry that is strictly younger.
  always_comb begin
    ins_pos = sort_n;
    for (int p = mlfq_pkg::MaxThreads - 1; p >= 0; p--) begin
      if ((mlfq_pkg::CountBits'(p) < sort_n) && (ages[p] < age_new)) begin
        ins_pos = mlfq_pkg::CountBits'(p);
      end
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick_sel   = '0;
    for (int lv = mlfq_pkg::Levels - 1; lv >= 0; lv--) begin
      if (fifo_count[lv] != '0) begin
        pick_found = 1'b1;
        pick_sel   = mlfq_pkg::LevelBits'(lv);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mlfq_pkg::S_IDLE: begin
        if (in_take) state_next = mlfq_pkg::S_DECODE;
      end
      mlfq_pkg::S_DECODE: begin
        if (in_q.cmd != mlfq_pkg::CMD_CREATE && is_event) begin
          state_next = promote ? mlfq_pkg::S_PR_POP : mlfq_pkg::S_ACT;
        end else begin
          state_next = mlfq_pkg::S_OUT;
        end
      end
      mlfq_pkg::S_PR_POP: begin
        state_next = (fifo_count[prom_lvl] != '0) ? mlfq_pkg::S_PR_BORN
                   : mlfq_pkg::S_PR_PUSH;
      end
      mlfq_pkg::S_PR_BORN: state_next = mlfq_pkg::S_PR_INS;
      mlfq_pkg::S_PR_INS:  state_next = mlfq_pkg::S_PR_POP;
      mlfq_pkg::S_PR_PUSH: begin
        if (!dist_more) begin
          state_next = (prom_lvl == mlfq_pkg::LevelBits'(mlfq_pkg::Levels - 1))
                     ? mlfq_pkg::S_ACT : mlfq_pkg::S_PR_POP;
        end
      end
      mlfq_pkg::S_ACT: begin
        state_next = (!cpu_idle && in_q.cmd == mlfq_pkg::CMD_EXIT) ? mlfq_pkg::S_WAKE
                   : mlfq_pkg::S_PICK;
      end
      mlfq_pkg::S_WAKE: begin
        if (wake_i == '0) state_next = mlfq_pkg::S_PICK;
      end
      mlfq_pkg::S_PICK: begin
        state_next = pick_found ? mlfq_pkg::S_PICK_RD : mlfq_pkg::S_OUT;
      end
      mlfq_pkg::S_PICK_RD: state_next = mlfq_pkg::S_OUT;
      mlfq_pkg::S_OUT: begin
        if (out_free) state_next = mlfq_pkg::S_IDLE;
      end
      default: state_next = mlfq_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshake and queue/RAM accesses
  always_comb begin
    in_stall   = (state != mlfq_pkg::S_IDLE);
    push_en    = 1'b0;
    push_lv    = '0;
    push_thr   = '0;
    pop_en     = 1'b0;
    pop_lv     = '0;
    born_we    = 1'b0;
    born_raddr = '0;
    case (state)
      mlfq_pkg::S_DECODE: begin
        if (in_q.cmd == mlfq_pkg::CMD_CREATE &&
            next_slot < mlfq_pkg::CountBits'(mlfq_pkg::MaxThreads)) begin
          push_en  = 1'b1;
          push_thr = next_slot[mlfq_pkg::ThreadBits-1:0];
          born_we  = 1'b1;
        end
      end
      mlfq_pkg::S_PR_POP: begin
        pop_lv = prom_lvl;
        pop_en = (fifo_count[prom_lvl] != '0);
      end
      mlfq_pkg::S_PR_BORN: born_raddr = fifo_rdata;
      mlfq_pkg::S_PR_PUSH: begin
        push_en  = dist_more;
        push_lv  = dist_dst;
        push_thr = dist_thr;
      end
      mlfq_pkg::S_ACT: begin
        if (!cpu_idle && in_q.cmd == mlfq_pkg::CMD_TIMEOUT) begin
          push_en  = 1'b1;
          push_lv  = tmo_lv;
          push_thr = running_thread;
        end else if (!cpu_idle && in_q.cmd == mlfq_pkg::CMD_YIELD) begin
          push_en  = 1'b1;
          push_lv  = cur_lv;
          push_thr = running_thread;
        end
      end
      mlfq_pkg::S_WAKE: begin
        push_en  = wake_hit;
        push_lv  = thread_level[wake_thr];
        push_thr = wake_thr;
      end
      mlfq_pkg::S_PICK: begin
        pop_en = pick_found;
        pop_lv = pick_sel;
      end
      default: ;
    endcase
  end

  assign push_ok    = push_en && (fifo_count[push_lv] < mlfq_pkg::CountBits'(mlfq_pkg::MaxThreads));
  assign fifo_we    = push_ok;
  assign fifo_waddr = {push_lv, fifo_head[push_lv] +
                       fifo_count[push_lv][mlfq_pkg::ThreadBits-1:0]};
  assign fifo_raddr = {pop_lv, fifo_head[pop_lv]};

  mlfq_ram #(
    .Width (mlfq_pkg::ThreadBits),
    .Depth (mlfq_pkg::FifoDepth)
  ) u_level_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (push_thr),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  mlfq_ram #(
    .Width (mlfq_pkg::TimeBits),
    .Depth (mlfq_pkg::MaxThreads)
  ) u_thread_born (
    .clk   (clk),
    .we    (born_we),
    .waddr (next_slot[mlfq_pkg::ThreadBits-1:0]),
    .wdata (in_q.now),
    .raddr (born_raddr),
    .rdata (born_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= mlfq_pkg::S_IDLE;
      quantum_ms       <= mlfq_pkg::QmsReset;
      rebalance_period <= mlfq_pkg::PeriodReset;
      quantum_base     <= mlfq_pkg::BaseBits'(50000);
      for (int i = 0; i < mlfq_pkg::Levels; i++) begin
        fifo_head[i]  <= '0;
        fifo_count[i] <= '0;
      end
      for (int i = 0; i < mlfq_pkg::MaxThreads; i++) begin
        thread_level[i] <= '0;
      end
      thread_live    <= mlfq_pkg::MaxThreads'(1);
      thread_dead    <= '0;
      join_depth     <= '0;
      running_thread <= '0;
      event_count    <= '0;
      next_slot      <= mlfq_pkg::CountBits'(1);
      cpu_idle       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      quantum_base <= mlfq_pkg::BaseBits'({10'b0, quantum_ms} *
                                          20'(mlfq_pkg::UsPerMs));

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mlfq_pkg::CFG_QUANTUM: quantum_ms <= cfg_data;
          mlfq_pkg::CFG_PERIOD:  rebalance_period <= cfg_data[mlfq_pkg::PeriodBits-1:0];
          default: ;
        endcase
      end

      // Queue bookkeeping; a push and a pop never fall in the same cycle.
      if (push_ok) begin
        fifo_count[push_lv]    <= fifo_count[push_lv] + 1'b1;
        thread_level[push_thr] <= push_lv;
      end
      if (pop_en) begin
        fifo_head[pop_lv]  <= fifo_head[pop_lv] + 1'b1;
        fifo_count[pop_lv] <= fifo_count[pop_lv] - 1'b1;
      end

      if (state == mlfq_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        mlfq_pkg::S_IDLE: begin
          if (in_take) in_q <= in_data;
        end
        mlfq_pkg::S_DECODE: begin
          if (in_q.cmd == mlfq_pkg::CMD_CREATE) begin
            res.level      <= '0;
            res.quantum_us <= '0;
            res.switched   <= 1'b0;
            if (next_slot < mlfq_pkg::CountBits'(mlfq_pkg::MaxThreads)) begin
              next_slot <= next_slot + 1'b1;
              thread_live[next_slot[mlfq_pkg::ThreadBits-1:0]] <= 1'b1;
              thread_dead[next_slot[mlfq_pkg::ThreadBits-1:0]] <= 1'b0;
              res.status <= mlfq_pkg::ST_OK;
              res.thread <= next_slot[mlfq_pkg::ThreadBits-1:0];
            end else begin
              res.status <= mlfq_pkg::ST_FULL;
              res.thread <= '0;
            end
          end else if (!is_event) begin
            res.status <= (in_q.cmd == mlfq_pkg::CMD_JOIN &&
                           !thread_live[in_q.target_thread]) ? mlfq_pkg::ST_UNKNOWN
                        : mlfq_pkg::ST_OK;
            res.thread     <= running_thread;
            res.level      <= rep_lv;
            res.quantum_us <= rep_q;
            res.switched   <= 1'b0;
          end else if (promote) begin
            event_count <= '0;
            prom_lvl    <= mlfq_pkg::LevelBits'(1);
            sort_n      <= '0;
          end else begin
            event_count <= ev_next;
          end
        end
        mlfq_pkg::S_PR_POP: begin
          if (fifo_count[prom_lvl] == '0) begin
            dist_share <= mlfq_pkg::share_of(sort_n, prom_lvl);
            dist_dst   <= (mlfq_pkg::share_of(sort_n, prom_lvl) == '0) ? '0 : prom_lvl;
            dist_k     <= '0;
            dist_idx   <= '0;
          end
        end
        mlfq_pkg::S_PR_BORN: pop_thr <= fifo_rdata;
        mlfq_pkg::S_PR_INS: begin
          for (int p = 1; p < mlfq_pkg::MaxThreads; p++) begin
            if (mlfq_pkg::CountBits'(p) > ins_pos) begin
              sort_buffer[p] <= sort_buffer[p-1];
              ages[p]        <= ages[p-1];
            end
          end
          sort_buffer[ins_pos[mlfq_pkg::ThreadBits-1:0]] <= pop_thr;
          ages[ins_pos[mlfq_pkg::ThreadBits-1:0]]        <= age_new;
          sort_n <= sort_n + 1'b1;
        end
        mlfq_pkg::S_PR_PUSH: begin
          if (dist_more) begin
            dist_idx <= dist_idx + 1'b1;
            if (dist_dst != '0) begin
              if (dist_k + 1'b1 == dist_share) begin
                dist_k   <= '0;
                dist_dst <= dist_dst - 1'b1;
              end else begin
                dist_k <= dist_k + 1'b1;
              end
            end
          end else begin
            prom_lvl <= prom_lvl + 1'b1;
            sort_n   <= '0;
          end
        end
        mlfq_pkg::S_ACT: begin
          if (!cpu_idle && in_q.cmd == mlfq_pkg::CMD_EXIT) begin
            thread_dead[running_thread] <= 1'b1;
            wake_i <= join_depth;
          end else if (!cpu_idle && in_q.cmd == mlfq_pkg::CMD_JOIN &&
                       join_depth < mlfq_pkg::CountBits'(mlfq_pkg::MaxThreads)) begin
            join_stack[join_depth[mlfq_pkg::ThreadBits-1:0]]  <= running_thread;
            join_target[join_depth[mlfq_pkg::ThreadBits-1:0]] <= in_q.target_thread;
            join_depth <= join_depth + 1'b1;
          end
        end
        mlfq_pkg::S_WAKE: begin
          if (wake_i != '0) begin
            wake_i <= wake_i - 1'b1;
            if (wake_hit) begin
              // Close the gap left by the woken entry.
              for (int j = 0; j < mlfq_pkg::MaxThreads - 1; j++) begin
                if (mlfq_pkg::ThreadBits'(j) >= wake_idx &&
                    mlfq_pkg::CountBits'(j + 1) < join_depth) begin
                  join_stack[j]  <= join_stack[j+1];
                  join_target[j] <= join_target[j+1];
                end
              end
              join_depth <= join_depth - 1'b1;
            end
          end
        end
        mlfq_pkg::S_PICK: begin
          if (pick_found) begin
            pick_lvl <= pick_sel;
          end else begin
            cpu_idle       <= 1'b1;
            res.status     <= mlfq_pkg::ST_NONE;
            res.thread     <= running_thread;
            res.level      <= '0;
            res.quantum_us <= '0;
            res.switched   <= 1'b0;
          end
        end
        mlfq_pkg::S_PICK_RD: begin
          running_thread           <= fifo_rdata;
          cpu_idle                 <= 1'b0;
          thread_level[fifo_rdata] <= pick_lvl;
          res.status     <= mlfq_pkg::ST_OK;
          res.thread     <= fifo_rdata;
          res.level      <= pick_lvl;
          res.quantum_us <= mlfq_pkg::slice_us(quantum_base, pick_lvl);
          res.switched   <= cpu_idle || (fifo_rdata != running_thread);
        end
        mlfq_pkg::S_OUT: begin
          if (out_free) begin
            out_data <= res;
          end
        end
        default: ;
      endcase
    end
  end

  // A single queue port pair is shared, so push and pop must never collide.
  a_push_pop_apart: assert property (@(posedge clk) disable iff (rst)
    !(push_en && pop_en))
    else $error("queue push and pop in the same cycle");

  a_join_depth: assert property (@(posedge clk) disable iff (rst)
    join_depth <= mlfq_pkg::CountBits'(mlfq_pkg::MaxThreads))
    else $error("join stack overflow");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == mlfq_pkg::S_DECODE)
    else $error("accepted beat not decoded");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == mlfq_pkg::S_OUT && out_free) |=> out_valid)
    else $error("result not presented");

  a_pick_runs: assert property (@(posedge clk) disable iff (rst)
    (state == mlfq_pkg::S_PICK_RD) |=> !cpu_idle)
    else $error("picked thread left scheduler idle");

endmodule

// File: bench/tb_mlfq_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// MLFQ thread scheduler core testbench
// Drives scheduler commands through a bursty sender against a stalling
// receiver. Every result beat is checked field by field against the directed
// table or a built-in scheduler predictor. A short directed table runs first,
// then random phases under several quantum and rebalance settings.
// ----------------------------------------------------------------------------
module tb_mlfq_thread_scheduler_core;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mlfq_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mlfq_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [mlfq_pkg::QmsBits-1:0] cfg_data = '0;

  mlfq_thread_scheduler_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Scheduler state mirrored by the predictor.
  mlfq_pkg::thread_t lvl_ring [mlfq_pkg::Levels][mlfq_pkg::MaxThreads];
  int                ring_head [mlfq_pkg::Levels];
  int                ring_cnt [mlfq_pkg::Levels];
  mlfq_pkg::level_t  th_level [mlfq_pkg::MaxThreads];
  mlfq_pkg::time_t   born [mlfq_pkg::MaxThreads];
  bit                live [mlfq_pkg::MaxThreads];
  bit                dead [mlfq_pkg::MaxThreads];
  mlfq_pkg::thread_t join_on [mlfq_pkg::MaxThreads];
  mlfq_pkg::thread_t joiner [mlfq_pkg::MaxThreads];
  int                join_cnt;
  mlfq_pkg::thread_t running;
  logic [7:0]        ev_count;
  int                free_slot;
  bit                cpu_idle;
  logic [mlfq_pkg::QmsBits-1:0]    base_ms;
  logic [mlfq_pkg::PeriodBits-1:0] period;

  mlfq_pkg::out_item_t sched_results [$];
  int        errors = 0;
  int        quiet_cycles = 0;

  typedef struct {
    logic [2:0]          cmd;
    mlfq_pkg::thread_t   tgt;
    mlfq_pkg::time_t     now;
    bit                  typed;
    mlfq_pkg::out_item_t result;
  } row_t;

  localparam int DirRows = 18;
  row_t dir_rows [DirRows] = '{
    '{mlfq_pkg::CMD_CREATE,  4'd0,  32'd10,       1,
      '{mlfq_pkg::ST_OK, 4'd1, 2'd0, 22'd0, 1'b0}},
    '{mlfq_pkg::CMD_TIMEOUT, 4'd0,  32'd20,       1,
      '{mlfq_pkg::ST_OK, 4'd1, 2'd0, 22'd50000, 1'b1}},
    '{mlfq_pkg::CMD_JOIN,    4'd15, 32'd21,       1,
      '{mlfq_pkg::ST_UNKNOWN, 4'd1, 2'd0, 22'd50000, 1'b0}},
    '{mlfq_pkg::CMD_JOIN,    4'd0,  32'd22,       1,
      '{mlfq_pkg::ST_OK, 4'd0, 2'd1, 22'd100000, 1'b1}},
    '{mlfq_pkg::CMD_EXIT,    4'd0,  32'd23,       1,
      '{mlfq_pkg::ST_OK, 4'd1, 2'd0, 22'd50000, 1'b1}},
    '{mlfq_pkg::CMD_EXIT,    4'd0,  32'd24,       1,
      '{mlfq_pkg::ST_NONE, 4'd1, 2'd0, 22'd0, 1'b0}},
    '{mlfq_pkg::CMD_YIELD,   4'd0,  32'd25,       1,
      '{mlfq_pkg::ST_NONE, 4'd1, 2'd0, 22'd0, 1'b0}},
    '{mlfq_pkg::CMD_JOIN,    4'd0,  32'd26,       1,
      '{mlfq_pkg::ST_OK, 4'd1, 2'd0, 22'd0, 1'b0}},
    '{3'd7,                  4'd0,  32'd27,       1,
      '{mlfq_pkg::ST_OK, 4'd1, 2'd0, 22'd0, 1'b0}},
    '{mlfq_pkg::CMD_CREATE,  4'd0,  32'hFFFFFFFF, 1,
      '{mlfq_pkg::ST_OK, 4'd2, 2'd0, 22'd0, 1'b0}},
    '{mlfq_pkg::CMD_TIMEOUT, 4'd0,  32'd30,       1,
      '{mlfq_pkg::ST_OK, 4'd2, 2'd0, 22'd50000, 1'b1}},
    '{mlfq_pkg::CMD_CREATE,  4'd0,  32'd0,        0, '0},
    '{mlfq_pkg::CMD_TIMEOUT, 4'd0,  32'd40,       0, '0},
    '{mlfq_pkg::CMD_TIMEOUT, 4'd0,  32'd50,       0, '0},
    '{mlfq_pkg::CMD_TIMEOUT, 4'd0,  32'd60,       0, '0},
    '{mlfq_pkg::CMD_YIELD,   4'd0,  32'd70,       0, '0},
    '{3'd5,                  4'd0,  32'd80,       0, '0},
    '{mlfq_pkg::CMD_JOIN,    4'd3,  32'hFFFFFFF0, 0, '0}
  };

  task automatic ring_push(input int lv, input mlfq_pkg::thread_t t);
    if (ring_cnt[lv] >= mlfq_pkg::MaxThreads) return;
    lvl_ring[lv][(ring_head[lv] + ring_cnt[lv]) % mlfq_pkg::MaxThreads] = t;
    ring_cnt[lv]++;
    th_level[t] = mlfq_pkg::level_t'(lv);
  endtask

  task automatic ring_pop(input int lv, output mlfq_pkg::thread_t t);
    t = lvl_ring[lv][ring_head[lv]];
    ring_head[lv] = (ring_head[lv] + 1) % mlfq_pkg::MaxThreads;
    ring_cnt[lv]--;
  endtask

  // Oldest first per lower level, then spread back up from that level.
  task automatic promote_levels(input mlfq_pkg::time_t now);
    mlfq_pkg::thread_t order [mlfq_pkg::MaxThreads];
    mlfq_pkg::time_t   ages [mlfq_pkg::MaxThreads];
    mlfq_pkg::thread_t t;
    mlfq_pkg::time_t   a;
    int n, pos, share, idx;
    for (int s = 1; s < mlfq_pkg::Levels; s++) begin
      n = 0;
      while (ring_cnt[s] > 0 && n < mlfq_pkg::MaxThreads) begin
        ring_pop(s, t);
        a = now - born[t];
        pos = n;
        for (int p = 0; p < n; p++) begin
          if (ages[p] < a) begin
            pos = p;
            break;
          end
        end
        for (int p = n; p > pos; p--) begin
          order[p] = order[p-1];
          ages[p] = ages[p-1];
        end
        order[pos] = t;
        ages[pos] = a;
        n++;
      end
      share = n / (s + 1);
      idx = 0;
      for (int d = s; d >= 1; d--) begin
        for (int k = 0; k < share; k++) begin
          ring_push(d, order[idx]);
          idx++;
        end
      end
      while (idx < n) begin
        ring_push(0, order[idx]);
        idx++;
      end
    end
  endtask

  function automatic logic [mlfq_pkg::QuantumBits-1:0] grant_us(input int lv);
    longint q;
    q = longint'(base_ms) * 1000 * (lv + 1);
    return (q > mlfq_pkg::QuantumMax) ? mlfq_pkg::QuantumMax
         : mlfq_pkg::QuantumBits'(q);
  endfunction

  function automatic mlfq_pkg::out_item_t report_running(input logic [1:0] st);
    mlfq_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.thread = running;
    if (!cpu_idle) begin
      r.level = th_level[running];
      r.quantum_us = grant_us(th_level[running]);
    end
    return r;
  endfunction

  task automatic wake_joiners(input mlfq_pkg::thread_t gone);
    mlfq_pkg::thread_t t;
    int i;
    i = join_cnt;
    while (i > 0) begin
      i--;
      if (join_on[i] == gone) begin
        t = joiner[i];
        for (int j = i; j + 1 < join_cnt; j++) begin
          joiner[j] = joiner[j+1];
          join_on[j] = join_on[j+1];
        end
        join_cnt--;
        ring_push(th_level[t], t);
      end
    end
  endtask

  task automatic schedule_step(input mlfq_pkg::in_item_t it,
                               output mlfq_pkg::out_item_t r);
    mlfq_pkg::thread_t cur, nxt;
    int lv;
    cur = running;
    r = '0;
    if (it.cmd == mlfq_pkg::CMD_CREATE) begin
      if (free_slot >= mlfq_pkg::MaxThreads) begin
        r.status = mlfq_pkg::ST_FULL;
        return;
      end
      live[free_slot] = 1;
      dead[free_slot] = 0;
      born[free_slot] = it.now;
      ring_push(0, mlfq_pkg::thread_t'(free_slot));
      r.thread = mlfq_pkg::thread_t'(free_slot);
      free_slot++;
      return;
    end
    if (it.cmd > mlfq_pkg::CMD_JOIN) begin
      r = report_running(mlfq_pkg::ST_OK);
      return;
    end
    if (it.cmd == mlfq_pkg::CMD_JOIN) begin
      if (!live[it.target_thread]) begin
        r = report_running(mlfq_pkg::ST_UNKNOWN);
        return;
      end
      if (dead[it.target_thread]) begin
        r = report_running(mlfq_pkg::ST_OK);
        return;
      end
    end
    ev_count = ev_count + 8'd1;
    if (ev_count >= period) begin
      ev_count = 0;
      promote_levels(it.now);
    end
    if (!cpu_idle) begin
      case (it.cmd)
        mlfq_pkg::CMD_TIMEOUT: begin
          lv = th_level[cur];
          if (lv + 1 < mlfq_pkg::Levels) lv++;
          ring_push(lv, cur);
        end
        mlfq_pkg::CMD_YIELD: ring_push(th_level[cur], cur);
        mlfq_pkg::CMD_EXIT: begin
          dead[cur] = 1;
          wake_joiners(cur);
        end
        default: begin
          if (join_cnt < mlfq_pkg::MaxThreads) begin
            joiner[join_cnt] = cur;
            join_on[join_cnt] = it.target_thread;
            join_cnt++;
          end
        end
      endcase
    end
    for (lv = 0; lv < mlfq_pkg::Levels; lv++) begin
      if (ring_cnt[lv] > 0) begin
        ring_pop(lv, nxt);
        r.status = mlfq_pkg::ST_OK;
        r.thread = nxt;
        r.level = mlfq_pkg::level_t'(lv);
        r.quantum_us = grant_us(lv);
        r.switched = cpu_idle || (nxt != cur);
        running = nxt;
        cpu_idle = 0;
        th_level[nxt] = mlfq_pkg::level_t'(lv);
        return;
      end
    end
    cpu_idle = 1;
    r.status = mlfq_pkg::ST_NONE;
    r.thread = running;
  endtask

  task automatic send_cmd(input mlfq_pkg::in_item_t it, input bit typed,
                          input mlfq_pkg::out_item_t typed_res);
    mlfq_pkg::out_item_t r;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    schedule_step(it, r);
    sched_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input mlfq_pkg::cfg_reg_t idx,
                           input logic [mlfq_pkg::QmsBits-1:0] val);
    in_valid <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mlfq_pkg::CFG_QUANTUM) base_ms = val;
    else period = val[mlfq_pkg::PeriodBits-1:0];
  endtask

  // Receiver stall pattern: switches between free-running, light and heavy.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  always @(posedge clk) begin
    mlfq_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (sched_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        e = sched_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.thread !== e.thread) begin
          $error("thread: expected %0d, got %0d", e.thread, out_data.thread);
          errors++;
        end
        if (out_data.level !== e.level) begin
          $error("level: expected %0d, got %0d", e.level, out_data.level);
          errors++;
        end
        if (out_data.quantum_us !== e.quantum_us) begin
          $error("quantum_us: expected %0d, got %0d", e.quantum_us, out_data.quantum_us);
          errors++;
        end
        if (out_data.switched !== e.switched) begin
          $error("switched: expected %0d, got %0d", e.switched, out_data.switched);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mlfq_pkg::in_item_t it;
    mlfq_pkg::time_t now_tick;
    int burst, r;
    logic [mlfq_pkg::QmsBits-1:0] q_set [4];
    logic [mlfq_pkg::QmsBits-1:0] p_set [4];

    q_set = '{10'd1, 10'd1000, 10'd1023, 10'd50};
    p_set = '{10'd1, 10'd255, 10'd0, 10'd3};
    for (int l = 0; l < mlfq_pkg::Levels; l++) begin
      ring_head[l] = 0;
      ring_cnt[l] = 0;
    end
    for (int t = 0; t < mlfq_pkg::MaxThreads; t++) begin
      th_level[t] = '0;
      born[t] = '0;
      live[t] = (t == 0);
      dead[t] = 0;
    end
    join_cnt = 0;
    running = '0;
    ev_count = '0;
    free_slot = 1;
    cpu_idle = 0;
    base_ms = mlfq_pkg::QmsReset;
    period = mlfq_pkg::PeriodReset;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.cmd = dir_rows[i].cmd;
      it.target_thread = dir_rows[i].tgt;
      it.now = dir_rows[i].now;
      send_cmd(it, dir_rows[i].typed, dir_rows[i].result);
    end

    now_tick = 32'd100;
    burst = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mlfq_pkg::CFG_QUANTUM, q_set[ph]);
      write_reg(mlfq_pkg::CFG_PERIOD, p_set[ph]);
      for (int n = 0; n < 350; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
          end
        end
        burst--;
        r = $urandom_range(0, 99);
        if (r < 3) it.cmd = mlfq_pkg::CMD_CREATE;
        else if (r < 35) it.cmd = mlfq_pkg::CMD_TIMEOUT;
        else if (r < 58) it.cmd = mlfq_pkg::CMD_YIELD;
        else if (r < 61) it.cmd = mlfq_pkg::CMD_EXIT;
        else if (r < 96) it.cmd = mlfq_pkg::CMD_JOIN;
        else it.cmd = 3'($urandom_range(5, 7));
        it.target_thread = mlfq_pkg::thread_t'($urandom_range(0, mlfq_pkg::MaxThreads - 1));
        // Mostly advancing time, with an occasional jump anywhere.
        if ($urandom_range(0, 19) == 0) now_tick = $urandom;
        else now_tick = now_tick + $urandom_range(0, 60);
        it.now = now_tick;
        send_cmd(it, 0, '0);
      end
    end
    in_valid <= 1'b0;

    while (sched_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
